FILE: rtl/ffea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_pkg: shared definitions of the first-fit extent allocator
// Table geometry, request and status codes, the extent record, the
// sequencer states and the operations of the shared adder.
// ----------------------------------------------------------------------------
package ffea_pkg;

	localparam int MAX_EXTENTS = 32;
	localparam int ADDR_BITS   = 32;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 32;
	localparam int SUM_W  = ADDR_W + 1;
	localparam int IDX_W  = $clog2(MAX_EXTENTS);
	localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);

	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_EXTENTS);
	// one past the last address of the address space
	localparam logic [SUM_W-1:0] ADDR_SPAN = SUM_W'(1) << ADDR_BITS;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FORCE = 2'd1,
		MODE_FREE  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// lim is base + len, kept so the scan needs compares only
	typedef struct packed {
		logic [SUM_W-1:0]  lim;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] base;
	} extent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_ALLOC1,
		S_ALLOC2,
		S_FORCE1,
		S_FLEFT,
		S_FRIGHT,
		S_FREE1,
		S_FREE2,
		S_FREE3,
		S_SHL,
		S_SHR,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/ffea_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/ffea_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_alu: shared adder of the allocator
// One 33-bit add or subtract, used at most once per sequencer step.
// ----------------------------------------------------------------------------
module ffea_alu import ffea_pkg::*; (
	input  wire alu_op_t          op,
	input  wire logic [SUM_W-1:0] a,
	input  wire logic [SUM_W-1:0] b,
	output logic      [SUM_W-1:0] y
);

	always_comb begin
		case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/first_fit_extent_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_extent_allocator: free-extent table with first-fit allocation
// Keeps free extents sorted by address, serves allocate, force allocate
// and free requests, merges touching extents on free.
// ----------------------------------------------------------------------------
// A request's wait from its accepted beat until its response is valid grows
// with N, the number of free extents in the table; it waits longer only while
// an earlier response is still stalled. The table lives in a memory with one
// read and one write port: the scan reads one extent per cycle, and inserting
// or removing an entry moves the entries behind it one per cycle. Every add
// and subtract on addresses and lengths, bound sums included, goes through a
// single shared 33-bit adder, one step per cycle. req_stall goes high once a
// beat is accepted and stays high until the result reaches the response
// register; that result may wait there while the next request is taken.
// Table entries need no clearing after reset: only the first count entries
// are ever read.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator import ffea_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        mode,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [LEN_W-1:0]  size,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [ADDR_W-1:0]      granted_address,
	output logic [1:0]             status
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              rv_q, rv_d;
	logic              rsp_valid_q, rsp_valid_d;

	logic [1:0]        mode_q, mode_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [LEN_W-1:0]  size_q, size_d;
	logic [SUM_W-1:0]  rend_q, rend_d;
	logic [CNT_W-1:0]  iss_q, iss_d;
	logic [IDX_W-1:0]  ridx_q, ridx_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	extent_t           cur_q, cur_d;
	extent_t           prv_q, prv_d;
	logic              prv_v_q, prv_v_d;
	logic              nxt_v_q, nxt_v_d;
	logic              flag_l_q, flag_l_d;
	logic              flag_r_q, flag_r_d;
	logic [SUM_W-1:0]  sum_l_q, sum_l_d;
	logic [SUM_W-1:0]  sum_r_q, sum_r_d;
	status_t           st_q, st_d;
	logic [ADDR_W-1:0] grant_q, grant_d;
	logic [ADDR_W-1:0] rsp_grant_q, rsp_grant_d;
	status_t           rsp_status_q, rsp_status_d;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	extent_t           ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	extent_t           rd;

	alu_op_t           alu_op;
	logic [SUM_W-1:0]  alu_a, alu_b, alu_y;

	logic [CNT_W-1:0]  iss_m1, pos_m1;
	logic              ml, mr, range_ok;

	ffea_ram #(
		.WIDTH ($bits(extent_t)),
		.DEPTH (MAX_EXTENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	ffea_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	assign iss_m1 = iss_q - CNT_W'(1);
	assign pos_m1 = pos_q - CNT_W'(1);

	// merge decisions of a free; left merge wins when merging both sides would overflow
	assign ml = flag_l_q && !sum_l_q[SUM_W-1];
	assign mr = flag_r_q && !sum_r_q[SUM_W-1] && !(ml && alu_y[SUM_W-1]);

	assign req_stall       = (state_q != S_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign granted_address = rsp_grant_q;
	assign status          = rsp_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rv_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rv_q        <= rv_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q       <= mode_d;
		addr_q       <= addr_d;
		size_q       <= size_d;
		rend_q       <= rend_d;
		iss_q        <= iss_d;
		ridx_q       <= ridx_d;
		pos_q        <= pos_d;
		cur_q        <= cur_d;
		prv_q        <= prv_d;
		prv_v_q      <= prv_v_d;
		nxt_v_q      <= nxt_v_d;
		flag_l_q     <= flag_l_d;
		flag_r_q     <= flag_r_d;
		sum_l_q      <= sum_l_d;
		sum_r_q      <= sum_r_d;
		st_q         <= st_d;
		grant_q      <= grant_d;
		rsp_grant_q  <= rsp_grant_d;
		rsp_status_q <= rsp_status_d;
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rv_d         = rv_q;
		rsp_valid_d  = rsp_valid_q;
		mode_d       = mode_q;
		addr_d       = addr_q;
		size_d       = size_q;
		rend_d       = rend_q;
		iss_d        = iss_q;
		ridx_d       = ridx_q;
		pos_d        = pos_q;
		cur_d        = cur_q;
		prv_d        = prv_q;
		prv_v_d      = prv_v_q;
		nxt_v_d      = nxt_v_q;
		flag_l_d     = flag_l_q;
		flag_r_d     = flag_r_q;
		sum_l_d      = sum_l_q;
		sum_r_d      = sum_r_q;
		st_d         = st_q;
		grant_d      = grant_q;
		rsp_grant_d  = rsp_grant_q;
		rsp_status_d = rsp_status_q;

		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_raddr = iss_q[IDX_W-1:0];

		alu_op   = ALU_ADD;
		alu_a    = '0;
		alu_b    = '0;
		range_ok = 1'b0;

		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					mode_d  = mode;
					addr_d  = address;
					size_d  = size;
					grant_d = '0;
					st_d    = ST_OK;
					state_d = S_CHECK;
				end
			end

			S_CHECK: begin
				alu_a  = {1'b0, addr_q};
				alu_b  = {1'b0, size_q};
				rend_d = alu_y;
				case (mode_q)
					MODE_ALLOC: range_ok = 1'b1;
					MODE_FORCE,
					MODE_FREE:  range_ok = (alu_y <= ADDR_SPAN);
					default:    range_ok = 1'b0;
				endcase
				if (!range_ok || size_q == '0) begin
					st_d    = ST_INVALID;
					state_d = S_DONE;
				end else begin
					iss_d   = '0;
					rv_d    = 1'b0;
					prv_v_d = 1'b0;
					nxt_v_d = 1'b0;
					state_d = S_SCAN;
				end
			end

			// one extent read per cycle, data checked the cycle after
			S_SCAN: begin
				if (iss_q < count_q) begin
					rv_d   = 1'b1;
					ridx_d = iss_q[IDX_W-1:0];
					iss_d  = iss_q + CNT_W'(1);
				end else begin
					rv_d = 1'b0;
				end
				if (rv_q) begin
					case (mode_q)
						MODE_ALLOC: begin
							if (rd.len >= size_q) begin
								cur_d   = rd;
								pos_d   = CNT_W'(ridx_q);
								grant_d = rd.base;
								if (rd.len == size_q) begin
									iss_d   = CNT_W'(ridx_q) + CNT_W'(1);
									rv_d    = 1'b0;
									state_d = S_SHL;
								end else begin
									state_d = S_ALLOC1;
								end
							end
						end
						MODE_FORCE: begin
							if (rd.base <= addr_q && {1'b0, addr_q} < rd.lim) begin
								if (rend_q > rd.lim) begin
									st_d    = ST_NOFIT;
									state_d = S_DONE;
								end else begin
									cur_d    = rd;
									pos_d    = CNT_W'(ridx_q);
									flag_l_d = (addr_q != rd.base);
									flag_r_d = (rend_q != rd.lim);
									state_d  = S_FORCE1;
								end
							end
						end
						MODE_FREE: begin
							if (rd.base > addr_q) begin
								nxt_v_d = 1'b1;
								cur_d   = rd;
								pos_d   = CNT_W'(ridx_q);
								state_d = S_FREE1;
							end else begin
								prv_d   = rd;
								prv_v_d = 1'b1;
							end
						end
						default: begin
							st_d    = ST_INVALID;
							state_d = S_DONE;
						end
					endcase
				end else if (iss_q >= count_q) begin
					if (mode_q == MODE_FREE) begin
						pos_d   = count_q;
						state_d = S_FREE1;
					end else begin
						st_d    = ST_NOFIT;
						state_d = S_DONE;
					end
				end
			end

			S_ALLOC1: begin
				alu_a   = {1'b0, cur_q.base};
				alu_b   = {1'b0, size_q};
				sum_l_d = alu_y;
				state_d = S_ALLOC2;
			end

			S_ALLOC2: begin
				alu_op    = ALU_SUB;
				alu_a     = {1'b0, cur_q.len};
				alu_b     = {1'b0, size_q};
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				ram_wdata = '{lim: cur_q.lim, len: alu_y[LEN_W-1:0],
				              base: sum_l_q[ADDR_W-1:0]};
				state_d   = S_DONE;
			end

			S_FORCE1: begin
				if (flag_l_q && flag_r_q && count_q == MAX_CNT) begin
					st_d    = ST_FULL;
					state_d = S_DONE;
				end else if (!flag_l_q && !flag_r_q) begin
					iss_d   = pos_q + CNT_W'(1);
					rv_d    = 1'b0;
					state_d = S_SHL;
				end else if (flag_l_q) begin
					state_d = S_FLEFT;
				end else begin
					state_d = S_FRIGHT;
				end
			end

			S_FLEFT: begin
				alu_op    = ALU_SUB;
				alu_a     = {1'b0, addr_q};
				alu_b     = {1'b0, cur_q.base};
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				ram_wdata = '{lim: {1'b0, addr_q}, len: alu_y[LEN_W-1:0],
				              base: cur_q.base};
				state_d   = flag_r_q ? S_FRIGHT : S_DONE;
			end

			S_FRIGHT: begin
				alu_op = ALU_SUB;
				alu_a  = cur_q.lim;
				alu_b  = rend_q;
				if (flag_l_q) begin
					// split: right piece goes in as a new entry after the left one
					cur_d   = '{lim: cur_q.lim, len: alu_y[LEN_W-1:0],
					            base: rend_q[ADDR_W-1:0]};
					pos_d   = pos_q + CNT_W'(1);
					iss_d   = count_q;
					rv_d    = 1'b0;
					state_d = S_SHR;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[IDX_W-1:0];
					ram_wdata = '{lim: cur_q.lim, len: alu_y[LEN_W-1:0],
					              base: rend_q[ADDR_W-1:0]};
					state_d   = S_DONE;
				end
			end

			S_FREE1: begin
				alu_a   = {1'b0, prv_q.len};
				alu_b   = {1'b0, size_q};
				sum_l_d = alu_y;
				if ((prv_v_q && prv_q.lim > {1'b0, addr_q}) ||
				    (nxt_v_q && {1'b0, cur_q.base} < rend_q)) begin
					st_d    = ST_INVALID;
					state_d = S_DONE;
				end else begin
					flag_l_d = prv_v_q && (prv_q.lim == {1'b0, addr_q});
					flag_r_d = nxt_v_q && ({1'b0, cur_q.base} == rend_q);
					state_d  = S_FREE2;
				end
			end

			S_FREE2: begin
				alu_a   = {1'b0, cur_q.len};
				alu_b   = {1'b0, size_q};
				sum_r_d = alu_y;
				state_d = S_FREE3;
			end

			S_FREE3: begin
				alu_a = sum_l_q;
				alu_b = {1'b0, cur_q.len};
				if (ml && mr) begin
					ram_we    = 1'b1;
					ram_waddr = pos_m1[IDX_W-1:0];
					ram_wdata = '{lim: cur_q.lim, len: alu_y[LEN_W-1:0],
					              base: prv_q.base};
					iss_d     = pos_q + CNT_W'(1);
					rv_d      = 1'b0;
					state_d   = S_SHL;
				end else if (ml) begin
					ram_we    = 1'b1;
					ram_waddr = pos_m1[IDX_W-1:0];
					ram_wdata = '{lim: rend_q, len: sum_l_q[LEN_W-1:0],
					              base: prv_q.base};
					state_d   = S_DONE;
				end else if (mr) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[IDX_W-1:0];
					ram_wdata = '{lim: cur_q.lim, len: sum_r_q[LEN_W-1:0],
					              base: addr_q};
					state_d   = S_DONE;
				end else if (count_q == MAX_CNT) begin
					st_d    = ST_FULL;
					state_d = S_DONE;
				end else begin
					cur_d   = '{lim: rend_q, len: size_q, base: addr_q};
					iss_d   = count_q;
					rv_d    = 1'b0;
					state_d = S_SHR;
				end
			end

			// close the gap: entry k+1 moves down to k
			S_SHL: begin
				if (iss_q < count_q) begin
					rv_d   = 1'b1;
					ridx_d = iss_q[IDX_W-1:0];
					iss_d  = iss_q + CNT_W'(1);
				end else begin
					rv_d = 1'b0;
				end
				if (rv_q) begin
					ram_we    = 1'b1;
					ram_waddr = ridx_q - IDX_W'(1);
					ram_wdata = rd;
				end else if (iss_q >= count_q) begin
					count_d = count_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end

			// open a gap at pos: entries move up from the top, then cur_q lands
			S_SHR: begin
				ram_raddr = iss_m1[IDX_W-1:0];
				if (iss_q > pos_q) begin
					rv_d   = 1'b1;
					ridx_d = iss_m1[IDX_W-1:0];
					iss_d  = iss_m1;
				end else begin
					rv_d = 1'b0;
				end
				if (rv_q) begin
					ram_we    = 1'b1;
					ram_waddr = ridx_q + IDX_W'(1);
					ram_wdata = rd;
				end else if (iss_q <= pos_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[IDX_W-1:0];
					ram_wdata = cur_q;
					count_d   = count_q + CNT_W'(1);
					state_d   = S_DONE;
				end
			end

			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d  = 1'b1;
					rsp_grant_d  = (st_q == ST_OK) ? grant_q : '0;
					rsp_status_d = st_q;
					state_d      = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("extent count beyond table size");

	a_count_moves_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q) == S_SHL || $past(state_q) == S_SHR))
		else $error("extent count changed outside a shift");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= count_q))
		else $error("table write beyond the filled region");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q == ST_FULL) |-> (count_q == MAX_CNT))
		else $error("table full reported with free entries");

	a_grant_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && grant_q != '0) |->
		(mode_q == MODE_ALLOC && st_q == ST_OK))
		else $error("grant address on a request that is not a good allocate");
`endif

endmodule
`default_nettype wire
